>>> src/interchange_sort_by_name_assert.svh
// Assertion macros for the interchange sort block.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef INTERCHANGE_SORT_BY_NAME_ASSERT_SVH
`define INTERCHANGE_SORT_BY_NAME_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISORT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isort assertion failed");

// Next-cycle implication, checked outside reset.
`define ISORT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isort assertion failed");

`endif

>>> src/isort_pkg.sv
// Shared types, widths and the key canonicalization function for the
// interchange sort block. No dependencies.
package isort_pkg;

	localparam int unsigned KEY_W      = 64;
	localparam int unsigned TAG_W      = 6;
	localparam int unsigned NAME_BYTES = KEY_W / 8;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	// Sequencer controls toward the datapath.
	typedef struct packed {
		logic in_ready;
		logic mem_we;
		logic wsel_in;   // write the incoming record, else the held record
		logic mem_re;
		logic cur_load;  // held record takes the read data
		logic scan;      // compare held record against read data
		logic out_load;
		logic out_last;
		logic out_ovf;
	} ctl_t;

	// Keep the top nchars bytes, clear everything from the first zero byte on.
	function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw,
			input int unsigned nchars);
		logic [KEY_W-1:0] kept;
		logic             alive;
		logic [7:0]       b8;
		kept  = '0;
		alive = 1'b1;
		for (int unsigned b = 0; b < NAME_BYTES; b++) begin
			b8 = raw[KEY_W-1-8*b -: 8];
			if (b8 == 8'h00 || b >= nchars) begin
				alive = 1'b0;
			end
			if (alive) begin
				kept[KEY_W-1-8*b -: 8] = b8;
			end
		end
		return kept;
	endfunction

endpackage

>>> src/isort_if.sv
// Valid/ready channel interfaces for the interchange sort block.
// Depends on isort_pkg for field widths.
interface isort_rec_if;
	logic                          valid;
	logic                          ready;
	logic [isort_pkg::KEY_W-1:0]   name_key;
	logic [isort_pkg::TAG_W-1:0]   record_tag;
	logic                          last_record;

	modport source (output valid, output name_key, output record_tag, output last_record,
		input ready);
	modport sink (input valid, input name_key, input record_tag, input last_record,
		output ready);
endinterface

interface isort_res_if;
	logic                          valid;
	logic                          ready;
	logic [isort_pkg::KEY_W-1:0]   sorted_key;
	logic [isort_pkg::TAG_W-1:0]   sorted_tag;
	logic                          end_of_run;
	logic                          overflow;

	modport source (output valid, output sorted_key, output sorted_tag, output end_of_run,
		output overflow, input ready);
	modport sink (input valid, input sorted_key, input sorted_tag, input end_of_run,
		input overflow, output ready);
endinterface

>>> src/isort_mem.sv
// Record store: one write port, one read port with registered read data.
// Depends on isort_pkg for the record type.
module isort_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  isort_pkg::rec_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output isort_pkg::rec_t rdata
);
	import isort_pkg::*;

	rec_t mem_q [DEPTH];
	rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/isort_cmp.sv
// Shared compare-and-exchange unit: holds the record of the current
// position and swaps it with each later record that has a smaller key.
// Depends on isort_pkg.
module isort_cmp (
	input  logic            clk,
	input  isort_pkg::ctl_t ctl,
	input  isort_pkg::rec_t rdata,
	output isort_pkg::rec_t cur,
	output logic            swap
);
	import isort_pkg::*;

	rec_t cur_q;

	assign swap = ctl.scan && (cur_q.key > rdata.key);

	always_ff @(posedge clk) begin
		if (ctl.cur_load || swap) begin
			cur_q <= rdata;
		end
	end

	assign cur = cur_q;

endmodule

>>> src/isort_ctrl.sv
// Sequencer: load, interchange sort passes and readout of the record store.
// Depends on isort_pkg.
module isort_ctrl #(
	parameter int MAX_RECORDS = 64,
	parameter int AW          = 6,
	parameter int CW          = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	input  logic            out_free,
	input  logic            swap,
	output isort_pkg::ctl_t ctl,
	output logic [AW-1:0]   raddr,
	output logic [AW-1:0]   waddr
);
	import isort_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LDI  = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_WB   = 6'b001000,
		ST_ERD  = 6'b010000,
		ST_ELD  = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d, cnt_next, cnt_m1;
	logic          dropped_q, dropped_d, full;
	logic [AW-1:0] i_q, i_d, j_q, j_d, i_inc, j_inc, last_idx;

	assign full     = (count_q == CW'(MAX_RECORDS));
	assign cnt_next = full ? count_q : count_q + 1'b1;
	assign cnt_m1   = count_q - 1'b1;
	assign last_idx = cnt_m1[AW-1:0];
	assign i_inc    = i_q + 1'b1;
	assign j_inc    = j_q + 1'b1;

	always_comb begin
		ctl       = '0;
		raddr     = '0;
		waddr     = i_q;
		state_d   = state_q;
		count_d   = count_q;
		dropped_d = dropped_q;
		i_d       = i_q;
		j_d       = j_q;
		case (state_q)
			ST_IDLE: begin
				ctl.in_ready = 1'b1;
				if (in_valid) begin
					count_d = cnt_next;
					if (full) begin
						dropped_d = 1'b1;
					end else begin
						ctl.mem_we  = 1'b1;
						ctl.wsel_in = 1'b1;
						waddr       = count_q[AW-1:0];
					end
					if (in_last) begin
						i_d = '0;
						if (cnt_next >= CW'(2)) begin
							ctl.mem_re = 1'b1;
							state_d    = ST_LDI;
						end else begin
							state_d = ST_ERD;
						end
					end
				end
			end
			ST_LDI: begin
				ctl.cur_load = 1'b1;
				ctl.mem_re   = 1'b1;
				raddr        = i_inc;
				j_d          = i_inc;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (swap) begin
					ctl.mem_we = 1'b1;
					waddr      = j_q;
				end
				if (j_q == last_idx) begin
					state_d = ST_WB;
				end else begin
					ctl.mem_re = 1'b1;
					raddr      = j_inc;
					j_d        = j_inc;
				end
			end
			ST_WB: begin
				ctl.mem_we = 1'b1;
				waddr      = i_q;
				if (i_inc == last_idx) begin
					i_d     = '0;
					state_d = ST_ERD;
				end else begin
					ctl.mem_re = 1'b1;
					raddr      = i_inc;
					i_d        = i_inc;
					state_d    = ST_LDI;
				end
			end
			ST_ERD: begin
				ctl.mem_re = 1'b1;
				raddr      = i_q;
				state_d    = ST_ELD;
			end
			ST_ELD: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_last = (i_q == last_idx);
					ctl.out_ovf  = dropped_q;
					if (i_q == last_idx) begin
						count_d   = '0;
						dropped_d = 1'b0;
						state_d   = ST_IDLE;
					end else begin
						i_d     = i_inc;
						state_d = ST_ERD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			dropped_q <= dropped_d;
			i_q       <= i_d;
			j_q       <= j_d;
		end
	end

endmodule

>>> src/interchange_sort_by_name.sv
// Top level of the interchange sort block: channels, key canonicalization,
// output register. Depends on isort_pkg, isort_if, isort_mem, isort_cmp,
// isort_ctrl and the assertion header.
//
// Usage:
//  - records (sink): one request per record, name_key/record_tag/last_record.
//    Keys are cut to NAME_CHARS bytes and cleared after the first zero byte.
//  - sorted (source): one request per stored record, ascending by key, with
//    end_of_run on the last one and overflow set on all of them if any
//    record past MAX_RECORDS was dropped from the set.
//  - Loading takes one record per cycle. The request with last_record starts
//    the sort; records is not ready until the sorted set has been handed out.
//  - Sort time for n records is set by the single compare unit and the one
//    read port of the record store. Readout then reads each record from the
//    store and loads it into the output register while sorted is ready.
//  - If sorted stalls, the readout waits with the next record held in the
//    store's read register; the final result sits in the output register
//    while records is already accepted again for the next set.
//  - Reset clears the sequencer, record count, drop flag and output valid.
//    Store contents are not cleared; only entries written in the current
//    set are ever read.
module interchange_sort_by_name #(
	parameter int MAX_RECORDS = 64,
	parameter int NAME_CHARS  = 8
) (
	input logic         clk,
	input logic         arst_n,
	isort_rec_if.sink   records,
	isort_res_if.source sorted
);
	import isort_pkg::*;

	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);

	ctl_t          ctl;
	logic [AW-1:0] raddr, waddr;
	rec_t          in_rec, wdata, rdata, cur;
	logic          swap, out_free;

	// output register
	logic             out_valid_q;
	logic [KEY_W-1:0] out_key_q;
	logic [TAG_W-1:0] out_tag_q;
	logic             out_last_q, out_ovf_q;

	// canonical key makes a plain unsigned compare match string order
	assign in_rec.key = canon_key(records.name_key, NAME_CHARS);
	assign in_rec.tag = records.record_tag;

	// incoming record on load, otherwise the compare unit's held record
	assign wdata = ctl.wsel_in ? in_rec : cur;

	assign out_free = !out_valid_q || sorted.ready;

	isort_ctrl #(
		.MAX_RECORDS (MAX_RECORDS),
		.AW          (AW),
		.CW          (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (records.valid),
		.in_last  (records.last_record),
		.out_free (out_free),
		.swap     (swap),
		.ctl      (ctl),
		.raddr    (raddr),
		.waddr    (waddr)
	);

	isort_mem #(
		.DEPTH (MAX_RECORDS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (ctl.mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	isort_cmp u_cmp (
		.clk   (clk),
		.ctl   (ctl),
		.rdata (rdata),
		.cur   (cur),
		.swap  (swap)
	);

	assign records.ready = ctl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (sorted.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_key_q  <= rdata.key;
			out_tag_q  <= rdata.tag;
			out_last_q <= ctl.out_last;
			out_ovf_q  <= ctl.out_ovf;
		end
	end

	assign sorted.valid      = out_valid_q;
	assign sorted.sorted_key = out_key_q;
	assign sorted.sorted_tag = out_tag_q;
	assign sorted.end_of_run = out_last_q;
	assign sorted.overflow   = out_ovf_q;

	`include "interchange_sort_by_name_assert.svh"

	// never overwrite a result the receiver has not taken
	`ISORT_ASSERT_NOW(a_out_load_free, ctl.out_load, !out_valid_q || sorted.ready)
	// the store is not written while a result is being read out
	`ISORT_ASSERT_NOW(a_no_write_on_out, ctl.out_load, !ctl.mem_we)
	// no new record is taken while the compare unit is busy
	`ISORT_ASSERT_NOW(a_idle_no_scan, ctl.in_ready, !ctl.scan && !ctl.cur_load)
	// a loaded result is presented in the next cycle
	`ISORT_ASSERT_NEXT(a_load_shows, ctl.out_load, sorted.valid)

endmodule

>>> bench/tb_interchange_sort_by_name.sv
// Self-checking testbench for interchange_sort_by_name: loads record sets over the
// records channel and checks every sorted request against an in-bench ordering model.
// Depends on isort_pkg, isort_if and the RTL of the block; reads no files.
module tb_interchange_sort_by_name;

	import isort_pkg::*;

	localparam int MAX_RECORDS    = 64;
	localparam int NAME_CHARS     = 8;
	localparam int RANDOM_RECORDS = 340;   // random part, on top of the directed sets
	localparam int HOLD_CYCLES    = 1500;  // one long stall on the sorted side
	localparam int HOLD_AFTER     = 30;    // sorted requests taken before that stall
	localparam int TAIL_CYCLES    = 64;
	// A full set sorts with nothing moving on either channel. The long
	// stall can land on top of that, so allow a wide margin.
	localparam int WATCHDOG       = 20000;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             end_of_run;
		logic             overflow;
	} sorted_rec_t;

	// Ordering model: holds the current set and, on the closing request,
	// queues the sorted set in the order the block must hand it out.
	class name_order_board;
		logic [KEY_W-1:0] held_key [MAX_RECORDS];
		logic [TAG_W-1:0] held_tag [MAX_RECORDS];
		int unsigned      held_count;
		bit               lost_any;
		sorted_rec_t      expected_sorted [$];
		int unsigned      bad_results;
		int unsigned      results_seen;

		function new();
			held_count   = 0;
			lost_any     = 1'b0;
			bad_results  = 0;
			results_seen = 0;
		endfunction

		function void take_record(logic [KEY_W-1:0] raw, logic [TAG_W-1:0] tag, logic last);
			logic [KEY_W-1:0] key;
			logic [KEY_W-1:0] swap_key;
			logic [TAG_W-1:0] swap_tag;
			logic [7:0]       ch;
			bit               ended;
			sorted_rec_t      rec;
			key   = '0;
			ended = 1'b0;
			// Name as a C string: stop at the first NUL or at NAME_CHARS.
			for (int b = 0; b < 8; b++) begin
				ch = raw[63-8*b -: 8];
				if (ch == 8'h00 || b >= NAME_CHARS)
					ended = 1'b1;
				if (!ended)
					key[63-8*b -: 8] = ch;
			end
			if (held_count < MAX_RECORDS) begin
				held_key[held_count] = key;
				held_tag[held_count] = tag;
				held_count++;
			end else begin
				lost_any = 1'b1;
			end
			if (!last)
				return;
			// Plain interchange sort; the order of equal keys falls out of it.
			for (int i = 0; i + 1 < held_count; i++) begin
				for (int j = i + 1; j < held_count; j++) begin
					if (held_key[i] > held_key[j]) begin
						swap_key    = held_key[i];
						swap_tag    = held_tag[i];
						held_key[i] = held_key[j];
						held_tag[i] = held_tag[j];
						held_key[j] = swap_key;
						held_tag[j] = swap_tag;
					end
				end
			end
			for (int k = 0; k < held_count; k++) begin
				rec.key        = held_key[k];
				rec.tag        = held_tag[k];
				rec.end_of_run = (k + 1 == held_count);
				rec.overflow   = lost_any;
				expected_sorted.push_back(rec);
			end
			held_count = 0;
			lost_any   = 1'b0;
		endfunction

		function void check_sorted(sorted_rec_t got);
			sorted_rec_t exp;
			results_seen++;
			if (expected_sorted.size() == 0) begin
				if (bad_results < 10)
					$display("sorted #%0d: unexpected request key %h tag %0d end %0b ovf %0b",
						results_seen, got.key, got.tag, got.end_of_run, got.overflow);
				bad_results++;
				return;
			end
			exp = expected_sorted.pop_front();
			if (got.key !== exp.key || got.tag !== exp.tag ||
					got.end_of_run !== exp.end_of_run || got.overflow !== exp.overflow) begin
				if (bad_results < 10)
					$display("sorted #%0d: exp key %h tag %0d end %0b ovf %0b, got key %h tag %0d end %0b ovf %0b",
						results_seen, exp.key, exp.tag, exp.end_of_run, exp.overflow,
						got.key, got.tag, got.end_of_run, got.overflow);
				bad_results++;
			end
		endfunction

		function int unsigned pending();
			return expected_sorted.size();
		endfunction

		// Anything still queued at the end is a missing request.
		function int unsigned failures();
			return bad_results + expected_sorted.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	isort_rec_if records_ch ();
	isort_res_if sorted_ch ();

	interchange_sort_by_name #(
		.MAX_RECORDS (MAX_RECORDS),
		.NAME_CHARS  (NAME_CHARS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.records (records_ch),
		.sorted  (sorted_ch)
	);

	name_order_board board = new();

	bit               calm_send;      // no gaps between record requests
	int unsigned      quiet_cycles;
	logic [KEY_W-1:0] name_pool [6];  // shared names, so sets carry equal keys
	int unsigned      pool_len  [6];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Monitor: both channels sampled at the rising edge, before any
	// nonblocking update of that edge lands. Also the stall watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (records_ch.valid && records_ch.ready)
				board.take_record(records_ch.name_key, records_ch.record_tag,
					records_ch.last_record);
			if (sorted_ch.valid && sorted_ch.ready)
				board.check_sorted({sorted_ch.sorted_key, sorted_ch.sorted_tag,
					sorted_ch.end_of_run, sorted_ch.overflow});
			if ((records_ch.valid && records_ch.ready) || (sorted_ch.valid && sorted_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG) begin
				$display("interchange_sort_by_name: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Sorted side: random stall before each request, calm stretches with
	// ready held high, and one long stall so the block backs up and the
	// records side stops taking requests.
	initial begin
		int unsigned gap;
		int unsigned taken;
		bit          calm;
		bit          held;
		taken = 0;
		calm  = 1'b0;
		held  = 1'b0;
		sorted_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 7);
			if (!held && taken >= HOLD_AFTER) begin
				held = 1'b1;
				sorted_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (gap != 0) begin
				sorted_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			sorted_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!sorted_ch.valid);
			taken++;
		end
	end

	// One record request. valid stays up into the next request when no gap
	// is drawn, so it never drops and rises within one step.
	task automatic send_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
		int unsigned gap;
		gap = calm_send ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			records_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		records_ch.valid       <= 1'b1;
		records_ch.name_key    <= key;
		records_ch.record_tag  <= tag;
		records_ch.last_record <= last;
		do
			@(posedge clk);
		while (!records_ch.ready);
	endtask

	// Stop offering and wait until every queued sorted request has come.
	task automatic drain_results();
		records_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// One set of random records, the last request closing it. Keys mix raw
	// noise, shared names (ties, with junk after the NUL), random strings
	// and very short names from a narrow alphabet.
	task automatic random_set(int unsigned set_size);
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] junk;
		int unsigned      p;
		int unsigned      len;
		int unsigned      mode;
		for (int unsigned n = 0; n < set_size; n++) begin
			mode = $urandom_range(0, 9);
			junk = {$urandom(), $urandom()};
			key  = '0;
			if (mode <= 2) begin
				key = junk;
			end else if (mode <= 5) begin
				p   = $urandom_range(0, 5);
				key = name_pool[p];
				if (pool_len[p] < 8)
					key |= junk & ((64'd1 << (8 * (7 - pool_len[p]))) - 64'd1);
			end else if (mode <= 8) begin
				len = $urandom_range(0, 8);
				for (int b = 0; b < 8; b++) begin
					if (b < len)
						key[63-8*b -: 8] = 8'($urandom_range(32, 126));
					else if (b > len)
						key[63-8*b -: 8] = junk[8*b +: 8];
				end
			end else begin
				key[63:56] = 8'($urandom_range(65, 67));
				if ($urandom_range(0, 1))
					key[55:48] = 8'($urandom_range(65, 67));
				else
					key[47:0] = junk[47:0];
			end
			send_record(key, 6'($urandom_range(0, 63)), n + 1 == set_size);
		end
	endtask

	// Stimulus: reset, directed sets, one drain pause, then random sets.
	initial begin
		int unsigned sent;
		int unsigned set_no;
		int unsigned set_size;
		arst_n                 <= 1'b0;
		records_ch.valid       <= 1'b0;
		records_ch.name_key    <= '0;
		records_ch.record_tag  <= '0;
		records_ch.last_record <= 1'b0;
		calm_send    = 1'b0;
		quiet_cycles = 0;
		for (int p = 0; p < 6; p++) begin
			pool_len[p]  = (p == 0) ? 8 : $urandom_range(1, 7);
			name_pool[p] = '0;
			for (int b = 0; b < pool_len[p]; b++)
				name_pool[p][63-8*b -: 8] = 8'($urandom_range(33, 126));
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-record sets at both key extremes.
		send_record(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1);
		send_record(64'h0, 6'd0, 1'b1);
		// Canonical key: NUL in the middle clears the tail, leading NUL
		// gives an empty name, full eight characters kept whole.
		send_record(64'h4142_4344_4546_4748, 6'd1, 1'b0);
		send_record(64'h4100_FFFF_FFFF_FFFF, 6'd2, 1'b0);
		send_record(64'h4100_0000_0000_0000, 6'd3, 1'b0);
		send_record(64'h00AB_CDEF_0123_4567, 6'd4, 1'b0);
		send_record(64'hFFFF_FFFF_FFFF_FFFF, 6'd5, 1'b0);
		send_record(64'h4142_4344_4546_4749, 6'd6, 1'b1);
		// Descending names with a repeat, so most compares swap.
		send_record(64'h4500_0000_0000_0000, 6'd10, 1'b0);
		send_record(64'h4400_0000_0000_0000, 6'd11, 1'b0);
		send_record(64'h4500_1234_0000_0000, 6'd12, 1'b0);
		send_record(64'h4200_0000_0000_0000, 6'd13, 1'b0);
		send_record(64'h4100_0000_0000_0000, 6'd14, 1'b1);
		// All keys equal: the tag order shows how ties come out.
		send_record(64'h4D41_5259_0000_0000, 6'd20, 1'b0);
		send_record(64'h4D41_5259_00FF_0000, 6'd21, 1'b0);
		send_record(64'h4D41_5259_0000_0000, 6'd22, 1'b0);
		send_record(64'h4D41_5259_0000_00AA, 6'd23, 1'b1);
		drain_results();

		// Random sets, mostly small. Set 4 fills the store exactly; set 12
		// overruns it, so the closing request itself is dropped too.
		sent   = 0;
		set_no = 0;
		while (sent < RANDOM_RECORDS) begin
			calm_send = ($urandom_range(0, 3) == 0);
			if (set_no == 4)
				set_size = MAX_RECORDS;
			else if (set_no == 12)
				set_size = MAX_RECORDS + 3;
			else if ($urandom_range(0, 7) == 0)
				set_size = $urandom_range(13, 30);
			else
				set_size = $urandom_range(1, 12);
			random_set(set_size);
			sent += set_size;
			set_no++;
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.failures() == 0)
			$display("interchange_sort_by_name: match");
		else
			$display("interchange_sort_by_name: mismatch");
		$finish;
	end

endmodule
